### sv/fesp_pkg.sv
// shared types, constants and helpers for the float exponent/significand split
`timescale 1ns / 1ps
`default_nettype none
package fesp_pkg;

    localparam int          MANT_W    = 23;
    localparam int          LZC_W     = 5;
    localparam logic [7:0]  BEXP_MAX  = 8'hFF;
    localparam logic [7:0]  BEXP_MIN  = 8'h00;
    localparam logic [15:0] EXP_SAT   = 16'h7FFF;
    localparam logic [15:0] EXP_ZERO  = 16'h8001;
    localparam logic [15:0] EXP_BIAS  = 16'd127;
    localparam logic [31:0] SIG_NAN   = 32'hFFFF_FFFF;
    localparam logic [31:0] SIG_NONE  = 32'h0000_0000;

    // input classes
    typedef enum logic [2:0] {
        CLS_NORMAL = 3'd0,
        CLS_SUB    = 3'd1,
        CLS_ZERO   = 3'd2,
        CLS_INF    = 3'd3,
        CLS_NAN    = 3'd4
    } t_cls;

    // stage 1 -> stage 2
    typedef struct packed {
        logic              sign;
        t_cls              cls;
        logic [7:0]        bexp;
        logic [MANT_W-1:0] mant;
        logic [LZC_W-1:0]  lzc;
    } t_dec;

    // stage 2 -> stage 3
    typedef struct packed {
        logic        sign;
        t_cls        cls;
        logic [15:0] expo;
        logic [31:0] sig;
    } t_nrm;

    // leading zeros of the mantissa field, only meaningful for a nonzero value
    function automatic logic [LZC_W-1:0] mant_lzc(input logic [MANT_W-1:0] mant);
        logic [LZC_W-1:0] n;
        n = '0;
        for (int i = 0; i < MANT_W; i++) begin
            if (mant[i]) begin
                n = LZC_W'(MANT_W - 1 - i);
            end
        end
        return n;
    endfunction

endpackage
`default_nettype wire

### sv/float_exponent_significand_split.sv
// top level of the single-precision float exponent/significand split
`timescale 1ns / 1ps
`default_nettype none
// Splits an IEEE-754 single-precision bit pattern into an exponent word (sign in
// bit 31, signed 16-bit exponent in bits 15:0) and a significand word with the
// leading one in bit 31; subnormals are normalized, zero, infinity and NaN give
// their fixed codes. Three register stages (decode with leading-zero count,
// normalizing shift, word assembly into the output register) carry each item in
// that order, and one item is taken every cycle while the output is being
// drained. A stall holds the pipeline; empty stages still fill, so the input
// stays ready until all three stages hold data.
module float_exponent_significand_split (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_float_bits,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_exponent_word,
    output logic [31:0]      o_significand_word
);
    import fesp_pkg::*;

    logic vld_dec;
    logic rdy_dec;
    t_dec dec;
    logic vld_nrm;
    logic rdy_nrm;
    t_nrm nrm;
    logic rdy_pack;

    assign rdy_dec = rdy_nrm;

    fesp_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vld        (i_valid),
        .i_float_bits (i_float_bits),
        .o_rdy        (o_ready),
        .o_vld        (vld_dec),
        .o_dec        (dec),
        .i_rdy_nxt    (rdy_dec)
    );

    fesp_norm u_norm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (vld_dec),
        .i_dec     (dec),
        .o_rdy     (rdy_nrm),
        .o_vld     (vld_nrm),
        .o_nrm     (nrm),
        .i_rdy_nxt (rdy_pack)
    );

    fesp_pack u_pack (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_vld              (vld_nrm),
        .i_nrm              (nrm),
        .o_rdy              (rdy_pack),
        .o_vld              (o_valid),
        .o_exponent_word    (o_exponent_word),
        .o_significand_word (o_significand_word),
        .i_rdy_nxt          (i_ready)
    );

endmodule
`default_nettype wire

### sv/fesp_decode.sv
// stage 1: field split, classification and leading-zero count
`timescale 1ns / 1ps
`default_nettype none
module fesp_decode (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_vld,
    input  wire logic [31:0]   i_float_bits,
    output logic               o_rdy,
    output logic               o_vld,
    output fesp_pkg::t_dec     o_dec,
    input  wire logic          i_rdy_nxt
);
    import fesp_pkg::*;

    logic r_vld;
    t_dec r_dec;
    t_dec n_dec;

    assign o_rdy = !r_vld || i_rdy_nxt;

    always_comb begin
        n_dec.sign = i_float_bits[31];
        n_dec.bexp = i_float_bits[30:23];
        n_dec.mant = i_float_bits[MANT_W-1:0];
        n_dec.lzc  = mant_lzc(i_float_bits[MANT_W-1:0]);
        if (n_dec.bexp == BEXP_MAX) begin
            n_dec.cls = (n_dec.mant == '0) ? CLS_INF : CLS_NAN;
        end else if (n_dec.bexp == BEXP_MIN) begin
            n_dec.cls = (n_dec.mant == '0) ? CLS_ZERO : CLS_SUB;
        end else begin
            n_dec.cls = CLS_NORMAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_dec <= n_dec;
        end
    end

    assign o_vld = r_vld;
    assign o_dec = r_dec;

endmodule
`default_nettype wire

### sv/fesp_norm.sv
// stage 2: normalizing shift and unbiased exponent
`timescale 1ns / 1ps
`default_nettype none
module fesp_norm (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_vld,
    input  wire fesp_pkg::t_dec i_dec,
    output logic               o_rdy,
    output logic               o_vld,
    output fesp_pkg::t_nrm     o_nrm,
    input  wire logic          i_rdy_nxt
);
    import fesp_pkg::*;

    logic r_vld;
    t_nrm r_nrm;
    t_nrm n_nrm;

    assign o_rdy = !r_vld || i_rdy_nxt;

    always_comb begin
        n_nrm.sign = i_dec.sign;
        n_nrm.cls  = i_dec.cls;
        case (i_dec.cls)
            CLS_NORMAL: begin
                n_nrm.sig  = {1'b1, i_dec.mant, 8'b0};
                n_nrm.expo = {8'b0, i_dec.bexp} - EXP_BIAS;
            end
            CLS_SUB: begin
                // top set bit of the mantissa lands on bit 31
                n_nrm.sig  = {i_dec.mant, 9'b0} << i_dec.lzc;
                n_nrm.expo = 16'(0) - EXP_BIAS - {11'b0, i_dec.lzc};
            end
            CLS_ZERO: begin
                n_nrm.sig  = SIG_NONE;
                n_nrm.expo = EXP_ZERO;
            end
            CLS_INF: begin
                n_nrm.sig  = SIG_NONE;
                n_nrm.expo = EXP_SAT;
            end
            default: begin
                n_nrm.sig  = SIG_NAN;
                n_nrm.expo = EXP_SAT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_nrm <= n_nrm;
        end
    end

    assign o_vld = r_vld;
    assign o_nrm = r_nrm;

endmodule
`default_nettype wire

### sv/fesp_pack.sv
// stage 3: output word assembly and output register
`timescale 1ns / 1ps
`default_nettype none
module fesp_pack (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_vld,
    input  wire fesp_pkg::t_nrm i_nrm,
    output logic               o_rdy,
    output logic               o_vld,
    output logic [31:0]        o_exponent_word,
    output logic [31:0]        o_significand_word,
    input  wire logic          i_rdy_nxt
);
    import fesp_pkg::*;

    logic        r_vld;
    logic [31:0] r_exponent_word;
    logic [31:0] r_significand_word;
    logic [31:0] n_exponent_word;
    logic        n_sign;

    assign o_rdy = !r_vld || i_rdy_nxt;

    // nan drops the sign
    assign n_sign          = (i_nrm.cls == CLS_NAN) ? 1'b0 : i_nrm.sign;
    assign n_exponent_word = {n_sign, 15'b0, i_nrm.expo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_exponent_word    <= n_exponent_word;
            r_significand_word <= i_nrm.sig;
        end
    end

    assign o_vld              = r_vld;
    assign o_exponent_word    = r_exponent_word;
    assign o_significand_word = r_significand_word;

endmodule
`default_nettype wire
